[sv/avtrq_pkg.sv]
// Shared constants and types of the audio/video timestamp reorder queue.
package avtrq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W       = (CNT_W > 5) ? CNT_W : 5;

   localparam int STAMP_W  = 32;
   localparam int HANDLE_W = 16;
   localparam int THRESH_W = 5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_REORDER = 1'b0;
   localparam logic REG_THRESH  = 1'b1;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 5'd10;

   localparam logic FUNC_RESTART = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic step;
      logic emit;
   } avtrq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic has_result;
      logic out_free;
   } avtrq_status_type;

endpackage

[sv/avtrq_csr.sv]
// Configuration registers behind the APB-style port.
module avtrq_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [avtrq_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [avtrq_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [avtrq_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                  pready,
   output logic                                  cfg_reorder,
   output logic [avtrq_pkg::THRESH_W-1:0]        cfg_thresh
);

   logic                           reorder_ff, reorder_in;
   logic [avtrq_pkg::THRESH_W-1:0] thresh_ff, thresh_in;
   logic                           wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_comb begin
      reorder_in = reorder_ff;
      thresh_in  = thresh_ff;
      if (wr) begin
         case (paddr[2])
            avtrq_pkg::REG_REORDER: reorder_in = pwdata[0];
            avtrq_pkg::REG_THRESH:  thresh_in  = pwdata[avtrq_pkg::THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reorder_ff <= 1'b0;
         thresh_ff  <= avtrq_pkg::THRESH_RESET;
      end else begin
         reorder_ff <= reorder_in;
         thresh_ff  <= thresh_in;
      end
   end

   always_comb begin
      case (paddr[2])
         avtrq_pkg::REG_REORDER: prdata = {{(avtrq_pkg::CSR_DATA_W-1){1'b0}}, reorder_ff};
         avtrq_pkg::REG_THRESH:
            prdata = {{(avtrq_pkg::CSR_DATA_W-avtrq_pkg::THRESH_W){1'b0}}, thresh_ff};
         default: prdata = '0;
      endcase
   end

   assign cfg_reorder = reorder_ff;
   assign cfg_thresh  = thresh_ff;

endmodule

[sv/avtrq_ctrl.sv]
// Controller: accepts a descriptor, then holds until its result is released.
module avtrq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   output avtrq_pkg::avtrq_cmd_type      cmd,
   input  avtrq_pkg::avtrq_status_type   status
);

   typedef enum logic {IDLE, EMIT} state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.step = 1'b1;
               if (status.has_result) state_in = EMIT;
            end
         end
         EMIT: begin
            // wait for the output register to free up
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else       state_ff <= state_in;
   end

   assign req_stall = (state_ff == EMIT);

endmodule

[sv/avtrq_dp.sv]
// Datapath: sorted compare-cell store, kind counters, timestamp tracking, output register.
module avtrq_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  avtrq_pkg::avtrq_cmd_type            cmd,
   output avtrq_pkg::avtrq_status_type         status,
   input  logic                                cfg_reorder,
   input  logic [avtrq_pkg::THRESH_W-1:0]      cfg_thresh,
   input  logic                                req_func,
   input  logic [avtrq_pkg::STAMP_W-1:0]       req_stamp,
   input  logic                                req_video_flag,
   input  logic [avtrq_pkg::HANDLE_W-1:0]      req_handle,
   input  logic                                req_header_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [avtrq_pkg::STAMP_W-1:0]       rsp_out_stamp,
   output logic                                rsp_out_video_flag,
   output logic [avtrq_pkg::HANDLE_W-1:0]      rsp_out_handle,
   output logic                                rsp_monotonic
);

   localparam int QD   = avtrq_pkg::QUEUE_DEPTH;
   localparam int CW   = avtrq_pkg::CNT_W;
   localparam int MW   = avtrq_pkg::CMP_W;
   localparam int SW   = avtrq_pkg::STAMP_W;
   localparam int HW   = avtrq_pkg::HANDLE_W;

   logic [SW-1:0] stamp_ff  [QD];
   logic [SW-1:0] stamp_in  [QD];
   logic          kind_ff   [QD];
   logic          kind_in   [QD];
   logic [HW-1:0] handle_ff [QD];
   logic [HW-1:0] handle_in [QD];

   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] vid_cnt_ff, vid_cnt_in;
   logic [CW-1:0] aud_cnt_ff, aud_cnt_in;
   logic [SW-1:0] last_ff, last_in;
   logic          mono_ff, mono_in;

   logic          pend_bypass_ff, pend_bypass_in;
   logic [SW-1:0] byp_stamp_ff, byp_stamp_in;
   logic          byp_kind_ff, byp_kind_in;
   logic [HW-1:0] byp_handle_ff, byp_handle_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_stamp_ff, rsp_stamp_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [HW-1:0] rsp_handle_ff, rsp_handle_in;
   logic          rsp_mono_ff, rsp_mono_in;

   logic [QD-1:0] le;
   logic          full, is_msg, keep, do_insert, release_now;
   logic [CW-1:0] vid_nx, aud_nx;
   logic [MW-1:0] thr_raw, thr, vid_w, aud_w;

   // each cell compares its own stamp with the incoming one; the sorted
   // order makes the set of cells at or below it a prefix
   always_comb begin
      for (int i = 0; i < QD; i++) begin
         le[i] = (CW'(i) < occ_ff) && (stamp_ff[i] <= req_stamp);
      end
   end

   assign full      = (occ_ff == CW'(QD));
   assign is_msg    = (req_func != avtrq_pkg::FUNC_RESTART);
   assign keep      = is_msg && !(req_video_flag && !req_header_ok);
   assign do_insert = keep && cfg_reorder && !full;

   assign vid_nx = vid_cnt_ff + CW'(do_insert && req_video_flag);
   assign aud_nx = aud_cnt_ff + CW'(do_insert && !req_video_flag);

   // clamp the threshold to 1..depth
   assign thr_raw = MW'(cfg_thresh);
   assign thr     = (thr_raw == '0) ? MW'(1) : ((thr_raw > MW'(QD)) ? MW'(QD) : thr_raw);
   assign vid_w   = MW'(vid_nx);
   assign aud_w   = MW'(aud_nx);

   assign release_now = do_insert &&
      (((vid_w >= thr) && (aud_nx == '0)) ||
       ((aud_w >= thr) && (vid_nx == '0)) ||
       ((vid_nx != '0) && (aud_nx != '0)));

   assign status.has_result = keep && (!cfg_reorder || release_now);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      for (int i = 0; i < QD; i++) begin
         stamp_in[i]  = stamp_ff[i];
         kind_in[i]   = kind_ff[i];
         handle_in[i] = handle_ff[i];
      end
      occ_in         = occ_ff;
      vid_cnt_in     = vid_cnt_ff;
      aud_cnt_in     = aud_cnt_ff;
      last_in        = last_ff;
      mono_in        = mono_ff;
      pend_bypass_in = pend_bypass_ff;
      byp_stamp_in   = byp_stamp_ff;
      byp_kind_in    = byp_kind_ff;
      byp_handle_in  = byp_handle_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_stamp_in   = rsp_stamp_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_mono_in    = rsp_mono_ff;

      if (cmd.step) begin
         pend_bypass_in = !cfg_reorder;
         byp_stamp_in   = req_stamp;
         byp_kind_in    = req_video_flag;
         byp_handle_in  = req_handle;
         if (!is_msg) begin
            occ_in     = '0;
            vid_cnt_in = '0;
            aud_cnt_in = '0;
            last_in    = '0;
            mono_in    = 1'b1;
         end else begin
            if (!cfg_reorder && mono_ff && (last_ff != '0) && (req_stamp < last_ff))
               mono_in = 1'b0;
            last_in = req_stamp;
            if (do_insert) begin
               // cell 0: keep, or take the new entry
               if (!le[0]) begin
                  stamp_in[0]  = req_stamp;
                  kind_in[0]   = req_video_flag;
                  handle_in[0] = req_handle;
               end
               // later cells: keep, take the new entry, or shift from below
               for (int i = 1; i < QD; i++) begin
                  if (!le[i]) begin
                     if (le[i-1]) begin
                        stamp_in[i]  = req_stamp;
                        kind_in[i]   = req_video_flag;
                        handle_in[i] = req_handle;
                     end else begin
                        stamp_in[i]  = stamp_ff[i-1];
                        kind_in[i]   = kind_ff[i-1];
                        handle_in[i] = handle_ff[i-1];
                     end
                  end
               end
               occ_in     = occ_ff + CW'(1);
               vid_cnt_in = vid_nx;
               aud_cnt_in = aud_nx;
            end
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_mono_in  = mono_ff;
         if (pend_bypass_ff) begin
            rsp_stamp_in  = byp_stamp_ff;
            rsp_kind_in   = byp_kind_ff;
            rsp_handle_in = byp_handle_ff;
         end else begin
            rsp_stamp_in  = stamp_ff[0];
            rsp_kind_in   = kind_ff[0];
            rsp_handle_in = handle_ff[0];
            if (kind_ff[0]) begin
               if (vid_cnt_ff != '0) vid_cnt_in = vid_cnt_ff - CW'(1);
            end else begin
               if (aud_cnt_ff != '0) aud_cnt_in = aud_cnt_ff - CW'(1);
            end
            // drop the head and advance the rest
            for (int i = 0; i < QD - 1; i++) begin
               stamp_in[i]  = stamp_ff[i+1];
               kind_in[i]   = kind_ff[i+1];
               handle_in[i] = handle_ff[i+1];
            end
            occ_in = occ_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         vid_cnt_ff   <= '0;
         aud_cnt_ff   <= '0;
         last_ff      <= '0;
         mono_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         vid_cnt_ff   <= vid_cnt_in;
         aud_cnt_ff   <= aud_cnt_in;
         last_ff      <= last_in;
         mono_ff      <= mono_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QD; i++) begin
         stamp_ff[i]  <= stamp_in[i];
         kind_ff[i]   <= kind_in[i];
         handle_ff[i] <= handle_in[i];
      end
      pend_bypass_ff <= pend_bypass_in;
      byp_stamp_ff   <= byp_stamp_in;
      byp_kind_ff    <= byp_kind_in;
      byp_handle_ff  <= byp_handle_in;
      rsp_stamp_ff   <= rsp_stamp_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_mono_ff    <= rsp_mono_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_stamp      = rsp_stamp_ff;
   assign rsp_out_video_flag = rsp_kind_ff;
   assign rsp_out_handle     = rsp_handle_ff;
   assign rsp_monotonic      = rsp_mono_ff;

endmodule

[sv/av_timestamp_reorder_queue.sv]
// Top level of the audio/video timestamp reorder queue.
//
//   channel   direction  handshake                 payload
//   req       in         req_valid / req_stall     func, stamp, video_flag, handle, header_ok
//   rsp       out        rsp_valid / rsp_stall     out_stamp, out_video_flag, out_handle,
//                                                  monotonic
//   csr       in/out     psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// A descriptor that yields a result is first inserted or tracked, then released into
// the output register; the release waits while the output register still holds an
// untransferred result.
// Insertion goes through a row of compare cells, one per store slot.
// Reset is synchronous; the store contents are not cleared, only its fill count.
// req_stall is high while a result waits for the output register.
module av_timestamp_reorder_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [avtrq_pkg::STAMP_W-1:0]       req_stamp,
   input  logic                                req_video_flag,
   input  logic [avtrq_pkg::HANDLE_W-1:0]      req_handle,
   input  logic                                req_header_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [avtrq_pkg::STAMP_W-1:0]       rsp_out_stamp,
   output logic                                rsp_out_video_flag,
   output logic [avtrq_pkg::HANDLE_W-1:0]      rsp_out_handle,
   output logic                                rsp_monotonic,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [avtrq_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [avtrq_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [avtrq_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);

   avtrq_pkg::avtrq_cmd_type       cmd;
   avtrq_pkg::avtrq_status_type    status;
   logic                           cfg_reorder;
   logic [avtrq_pkg::THRESH_W-1:0] cfg_thresh;

   avtrq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .cfg_reorder (cfg_reorder),
      .cfg_thresh  (cfg_thresh)
   );

   avtrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   avtrq_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .cfg_reorder        (cfg_reorder),
      .cfg_thresh         (cfg_thresh),
      .req_func           (req_func),
      .req_stamp          (req_stamp),
      .req_video_flag     (req_video_flag),
      .req_handle         (req_handle),
      .req_header_ok      (req_header_ok),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_stamp      (rsp_out_stamp),
      .rsp_out_video_flag (rsp_out_video_flag),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_monotonic      (rsp_monotonic)
   );

endmodule
